// ===== hw/rtl/blpg_pkg.sv =====
package blpg_pkg;

  // fixed field widths
  localparam int OFFSET_BITS    = 25;
  localparam int COLOR_BITS     = 32;
  localparam int WIDTH_BITS     = 12;
  localparam int HEIGHT_BITS    = 12;
  localparam int PITCH_BITS     = 15;
  localparam int PBYTES_BITS    = 3;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 15;

  // register values after reset
  localparam logic [WIDTH_BITS-1:0]  SCREEN_WIDTH_RST  = 12'd960;
  localparam logic [HEIGHT_BITS-1:0] SCREEN_HEIGHT_RST = 12'd540;
  localparam logic [PITCH_BITS-1:0]  ROW_PITCH_RST     = 15'd3840;
  localparam logic [PBYTES_BITS-1:0] PIXEL_BYTES_RST   = 3'd4;

  // register indexes on the configuration port
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_ROW_PITCH     = 2'd2,
    REG_PIXEL_BYTES   = 2'd3
  } cfg_reg_t;

  // input word kinds
  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } cmd_t;

  // current register contents
  typedef struct packed {
    logic [WIDTH_BITS-1:0]  screen_width;
    logic [HEIGHT_BITS-1:0] screen_height;
    logic [PITCH_BITS-1:0]  row_pitch;
    logic [PBYTES_BITS-1:0] pixel_bytes;
  } cfg_t;

endpackage

// ===== hw/rtl/blpg_cfg.sv =====
module blpg_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [blpg_pkg::CFG_INDEX_BITS-1:0] cfg_addr,
  input  logic [blpg_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  output blpg_pkg::cfg_t                     cfg
);
  import blpg_pkg::*;

  // register file, write only
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width  <= SCREEN_WIDTH_RST;
      cfg.screen_height <= SCREEN_HEIGHT_RST;
      cfg.row_pitch     <= ROW_PITCH_RST;
      cfg.pixel_bytes   <= PIXEL_BYTES_RST;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_addr))
        REG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_wdata[WIDTH_BITS-1:0];
        REG_SCREEN_HEIGHT: cfg.screen_height <= cfg_wdata[HEIGHT_BITS-1:0];
        REG_ROW_PITCH:     cfg.row_pitch     <= cfg_wdata[PITCH_BITS-1:0];
        REG_PIXEL_BYTES:   cfg.pixel_bytes   <= cfg_wdata[PBYTES_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/blpg_addr.sv =====
module blpg_addr #(
  parameter int COORD_BITS = 12
) (
  input  blpg_pkg::cfg_t                     cfg,
  input  logic signed [COORD_BITS-1:0]       pix_x,
  input  logic signed [COORD_BITS-1:0]       pix_y,
  output logic                               on_screen,
  output logic [blpg_pkg::OFFSET_BITS-1:0]   offset
);
  import blpg_pkg::*;

  localparam int MAG_BITS  = COORD_BITS - 1;
  localparam int CMP_BITS  = (MAG_BITS > WIDTH_BITS) ? MAG_BITS : WIDTH_BITS;
  localparam int PROD_BITS = MAG_BITS + PITCH_BITS + 1;
  localparam int SUM_BITS  = (PROD_BITS > OFFSET_BITS) ? PROD_BITS : OFFSET_BITS;

  logic                x_ok;
  logic                y_ok;
  logic [SUM_BITS-1:0] sum;

  // clip test: non-negative and below the visible size
  assign x_ok = !pix_x[COORD_BITS-1] &&
                (CMP_BITS'(pix_x[MAG_BITS-1:0]) < CMP_BITS'(cfg.screen_width));
  assign y_ok = !pix_y[COORD_BITS-1] &&
                (CMP_BITS'(pix_y[MAG_BITS-1:0]) < CMP_BITS'(cfg.screen_height));
  assign on_screen = x_ok && y_ok;

  // y * pitch + x * bytes per pixel, kept to the offset width
  assign sum = SUM_BITS'(pix_y[MAG_BITS-1:0]) * SUM_BITS'(cfg.row_pitch) +
               SUM_BITS'(pix_x[MAG_BITS-1:0]) * SUM_BITS'(cfg.pixel_bytes);
  assign offset = on_screen ? sum[OFFSET_BITS-1:0] : '0;

endmodule

// ===== hw/rtl/blpg_core.sv =====
module blpg_core #(
  parameter int COORD_BITS = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  blpg_pkg::cfg_t                     cfg,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  blpg_pkg::cmd_t                     in_cmd,
  input  logic signed [COORD_BITS-1:0]       in_start_x,
  input  logic signed [COORD_BITS-1:0]       in_start_y,
  input  logic signed [COORD_BITS-1:0]       in_end_x,
  input  logic signed [COORD_BITS-1:0]       in_end_y,
  input  logic [blpg_pkg::COLOR_BITS-1:0]    in_color,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [COORD_BITS-1:0]       out_x,
  output logic signed [COORD_BITS-1:0]       out_y,
  output logic                               out_inside,
  output logic [blpg_pkg::OFFSET_BITS-1:0]   out_offset,
  output logic [blpg_pkg::COLOR_BITS-1:0]    out_color,
  output logic                               out_last
);
  import blpg_pkg::*;

  localparam int N  = COORD_BITS;
  localparam int EW = COORD_BITS + 2;
  localparam int PW = COORD_BITS + 3;

  // input register
  logic                  hold_valid;
  cmd_t                  hold_cmd;
  logic signed [N-1:0]   hold_sx;
  logic signed [N-1:0]   hold_sy;
  logic signed [N-1:0]   hold_ex;
  logic signed [N-1:0]   hold_ey;
  logic [COLOR_BITS-1:0] hold_color;

  // line walker state
  logic signed [N-1:0]   cur_x;
  logic signed [N-1:0]   cur_y;
  logic signed [N-1:0]   tgt_x;
  logic signed [N-1:0]   tgt_y;
  logic signed [EW-1:0]  err;
  logic signed [N:0]     abs_dx;
  logic signed [N:0]     neg_abs_dy;
  logic                  dir_x_neg;
  logic                  dir_y_neg;
  logic [COLOR_BITS-1:0] held_color;
  logic                  busy;

  // handshake control
  logic is_load;
  logic emit;
  logic res_ready;
  logic adv;

  // load setup
  logic signed [N:0]     ld_dx;
  logic signed [N:0]     ld_dy;
  logic signed [N:0]     ld_abs_dx;
  logic signed [N:0]     ld_neg_abs_dy;
  logic signed [EW-1:0]  ld_err;

  // one step
  logic signed [PW-1:0]  e2;
  logic signed [PW-1:0]  neg_ext;
  logic signed [PW-1:0]  abs_ext;
  logic signed [EW-1:0]  add_x;
  logic signed [EW-1:0]  add_y;
  logic                  take_x;
  logic                  take_y;
  logic                  x_done;
  logic                  y_done;
  logic                  move_x;
  logic                  move_y;
  logic                  done;
  logic signed [EW-1:0]  err_next;
  logic signed [N-1:0]   x_next;
  logic signed [N-1:0]   y_next;

  // pixel address
  logic                   pix_inside;
  logic [OFFSET_BITS-1:0] pix_offset;

  blpg_addr #(
    .COORD_BITS(COORD_BITS)
  ) u_addr (
    .cfg       (cfg),
    .pix_x     (cur_x),
    .pix_y     (cur_y),
    .on_screen (pix_inside),
    .offset    (pix_offset)
  );

  // a word moves on when it needs no result slot or the slot is free
  assign is_load   = (hold_cmd == CMD_LOAD);
  assign emit      = hold_valid && !is_load && busy;
  assign res_ready = !out_valid || out_ready;
  assign adv       = hold_valid && (!emit || res_ready);
  assign in_ready  = !hold_valid || adv;

  // deltas, directions and first error term
  assign ld_dx         = {hold_ex[N-1], hold_ex} - {hold_sx[N-1], hold_sx};
  assign ld_dy         = {hold_ey[N-1], hold_ey} - {hold_sy[N-1], hold_sy};
  assign ld_abs_dx     = ld_dx[N] ? -ld_dx : ld_dx;
  assign ld_neg_abs_dy = ld_dy[N] ? ld_dy : -ld_dy;
  assign ld_err        = {ld_abs_dx[N], ld_abs_dx} + {ld_neg_abs_dy[N], ld_neg_abs_dy};

  // bresenham decision on twice the error
  assign e2      = {err, 1'b0};
  assign neg_ext = {{2{neg_abs_dy[N]}}, neg_abs_dy};
  assign abs_ext = {{2{abs_dx[N]}}, abs_dx};
  assign take_x  = (e2 >= neg_ext);
  assign x_done  = take_x && (cur_x == tgt_x);
  assign move_x  = take_x && !x_done;
  assign take_y  = !x_done && (e2 <= abs_ext);
  assign y_done  = take_y && (cur_y == tgt_y);
  assign move_y  = take_y && !y_done;
  assign done    = x_done || y_done;

  assign add_x    = move_x ? {neg_abs_dy[N], neg_abs_dy} : '0;
  assign add_y    = move_y ? {abs_dx[N], abs_dx} : '0;
  assign err_next = err + add_x + add_y;
  assign x_next   = !move_x ? cur_x : (dir_x_neg ? cur_x - N'(1) : cur_x + N'(1));
  assign y_next   = !move_y ? cur_y : (dir_y_neg ? cur_y - N'(1) : cur_y + N'(1));

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      hold_cmd   <= in_cmd;
      hold_sx    <= in_start_x;
      hold_sy    <= in_start_y;
      hold_ex    <= in_end_x;
      hold_ey    <= in_end_y;
      hold_color <= in_color;
    end
  end

  // walker state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x      <= '0;
      cur_y      <= '0;
      tgt_x      <= '0;
      tgt_y      <= '0;
      err        <= '0;
      abs_dx     <= '0;
      neg_abs_dy <= '0;
      dir_x_neg  <= 1'b0;
      dir_y_neg  <= 1'b0;
      held_color <= '0;
      busy       <= 1'b0;
    end else if (adv && is_load) begin
      cur_x      <= hold_sx;
      cur_y      <= hold_sy;
      tgt_x      <= hold_ex;
      tgt_y      <= hold_ey;
      err        <= ld_err;
      abs_dx     <= ld_abs_dx;
      neg_abs_dy <= ld_neg_abs_dy;
      dir_x_neg  <= !(hold_sx < hold_ex);
      dir_y_neg  <= !(hold_sy < hold_ey);
      held_color <= hold_color;
      busy       <= 1'b1;
    end else if (adv && emit) begin
      cur_x <= x_next;
      cur_y <= y_next;
      err   <= err_next;
      busy  <= !done;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= emit;
    end
    if (emit && res_ready) begin
      out_x      <= cur_x;
      out_y      <= cur_y;
      out_inside <= pix_inside;
      out_offset <= pix_offset;
      out_color  <= held_color;
      out_last   <= done;
    end
  end

endmodule

// ===== hw/rtl/bresenham_line_pixel_generator.sv =====
// Bresenham line pixel generator with screen clipping.
// Slave stream: each word is a command in tuser. A load word carries start
// and end points and a colour; it sets up the line and gives no output word.
// A step word gives the next pixel of the line; a step with no line loaded
// is consumed and gives nothing. A load while a line is running drops it.
// Master stream: one word per pixel with coordinates, framebuffer byte
// offset (y * row_pitch + x * pixel_bytes, zero when clipped) and colour;
// tuser flags an on-screen pixel, tlast marks the final pixel of the line.
// Throughput: one word per cycle while the master side is not stalled;
// the pixel step and address multiply-add sit between the input register
// and the output register. Stalls: with the master side stalled, load
// words and steps with no line still pass through; the first pixel step
// waits in the input register and s_axis_tready stays low until the held
// output word is taken. Reset clears both registers, drops any line and
// restores the screen registers to 960 x 540, pitch 3840, 4 bytes per
// pixel. Registers are written through cfg_wr_en / cfg_addr / cfg_wdata;
// the user must write them only while idle; the block does not enforce it.
module bresenham_line_pixel_generator #(
  parameter int COORD_BITS = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [blpg_pkg::CFG_INDEX_BITS-1:0] cfg_addr,
  input  logic [blpg_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // start_x, start_y, end_x, end_y, line_color
  input  logic [((4*COORD_BITS+blpg_pkg::COLOR_BITS+7)/8)*8-1:0] s_axis_tdata,
  // command
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // pixel_x, pixel_y, byte_offset, pixel_color, zero fill
  output logic [((2*COORD_BITS+blpg_pkg::OFFSET_BITS+blpg_pkg::COLOR_BITS+7)/8)*8-1:0]
                                             m_axis_tdata,
  // inside_res
  output logic                               m_axis_tuser,
  output logic                               m_axis_tlast
);
  import blpg_pkg::*;

  localparam int N             = COORD_BITS;
  localparam int OUT_DATA_BITS = 2*N + OFFSET_BITS + COLOR_BITS;
  localparam int OUT_TDATA_BITS = ((OUT_DATA_BITS + 7) / 8) * 8;

  cfg_t                  cfg;
  logic signed [N-1:0]   pix_x;
  logic signed [N-1:0]   pix_y;
  logic [OFFSET_BITS-1:0] pix_offset;
  logic [COLOR_BITS-1:0] pix_color;

  blpg_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  blpg_core #(
    .COORD_BITS(COORD_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_cmd     (cmd_t'(s_axis_tuser)),
    .in_start_x (s_axis_tdata[0*N +: N]),
    .in_start_y (s_axis_tdata[1*N +: N]),
    .in_end_x   (s_axis_tdata[2*N +: N]),
    .in_end_y   (s_axis_tdata[3*N +: N]),
    .in_color   (s_axis_tdata[4*N +: COLOR_BITS]),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_x      (pix_x),
    .out_y      (pix_y),
    .out_inside (m_axis_tuser),
    .out_offset (pix_offset),
    .out_color  (pix_color),
    .out_last   (m_axis_tlast)
  );

  // output word packing, lowest field first
  assign m_axis_tdata = OUT_TDATA_BITS'({pix_color, pix_offset, pix_y, pix_x});

endmodule

// ===== hw/rtl/blpg_checker.sv =====
module blpg_checker #(
  parameter int COORD_BITS = 12
) (
  input logic clk,
  input logic rst,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [((2*COORD_BITS+blpg_pkg::OFFSET_BITS+blpg_pkg::COLOR_BITS+7)/8)*8-1:0]
              m_axis_tdata,
  input logic m_axis_tuser,
  input logic m_axis_tlast
);
  import blpg_pkg::*;

  localparam int N = COORD_BITS;

  // nothing comes out straight after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output word straight after reset");

  // a stalled word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled output word changed");

  // a clipped pixel has a zero offset
  a_clipped_offset: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[2*N +: OFFSET_BITS] == '0)
    else $error("clipped pixel with non-zero offset");

  // an on-screen pixel has non-negative coordinates
  a_inside_sign: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> !m_axis_tdata[N-1] && !m_axis_tdata[2*N-1])
    else $error("on-screen pixel with negative coordinate");

endmodule

bind bresenham_line_pixel_generator blpg_checker #(
  .COORD_BITS(COORD_BITS)
) u_blpg_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/sv/tb.sv =====
module tb;
  import blpg_pkg::*;

  localparam int CB        = 12;
  localparam int IN_W      = ((4*CB+COLOR_BITS+7)/8)*8;
  localparam int OUT_W     = ((2*CB+OFFSET_BITS+COLOR_BITS+7)/8)*8;
  localparam int CYCLE_CAP = 500000;
  localparam int PHASES    = 8;
  localparam int PHASE_LEN = 160;

  // one word on the input stream
  typedef struct {
    cmd_t             cmd;
    logic [CB-1:0]    sx;
    logic [CB-1:0]    sy;
    logic [CB-1:0]    ex;
    logic [CB-1:0]    ey;
    logic [31:0]      color;
  } stroke_t;

  // one pixel word on the output stream
  typedef struct packed {
    logic [CB-1:0]          px_x;
    logic [CB-1:0]          px_y;
    logic                   on_screen;
    logic [OFFSET_BITS-1:0] offset;
    logic [COLOR_BITS-1:0]  color;
    logic                   tail;
  } pixel_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_wr_en = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_addr = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [IN_W-1:0]           s_axis_tdata = '0;
  logic                      s_axis_tuser = 1'b0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [OUT_W-1:0]          m_axis_tdata;
  logic                      m_axis_tuser;
  logic                      m_axis_tlast;

  // words waiting to be sent and pixels waiting to arrive
  stroke_t stroke_q[$];
  pixel_t  pixel_q[$];

  // shadow of the screen registers
  cfg_t screen_cfg;

  // line walker state
  int          walk_x = 0;
  int          walk_y = 0;
  int          goal_x = 0;
  int          goal_y = 0;
  int          err_acc = 0;
  int          span_x = 0;
  int          neg_span_y = 0;
  bit          x_back = 1'b0;
  bit          y_back = 1'b0;
  logic [31:0] ink = '0;
  bit          drawing = 1'b0;

  int      errors = 0;
  int      cycle_cnt = 0;
  int      send_pace = 1;
  int      recv_pace = 1;
  int      send_wait = 0;
  int      recv_wait = 0;
  bit      hold_req = 1'b0;
  bit      hold_done = 1'b0;
  stroke_t on_bus;
  pixel_t  next_px;
  pixel_t  got_px;
  pixel_t  want_px;

  bresenham_line_pixel_generator #(.COORD_BITS(CB)) u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  // walk the line for one accepted word; returns 1 when a pixel is due
  function automatic bit trace_line(input stroke_t w, output pixel_t px);
    int sx;
    int sy;
    int ex;
    int ey;
    int dx;
    int dy;
    int e2;
    int lin;
    bit fin;
    bit on_scr;
    px = '0;
    if (w.cmd == CMD_LOAD) begin
      sx = int'($signed(w.sx));
      sy = int'($signed(w.sy));
      ex = int'($signed(w.ex));
      ey = int'($signed(w.ey));
      dx = ex - sx;
      dy = ey - sy;
      walk_x = sx;
      walk_y = sy;
      goal_x = ex;
      goal_y = ey;
      span_x = (dx < 0) ? -dx : dx;
      neg_span_y = (dy < 0) ? dy : -dy;
      x_back = !(sx < ex);
      y_back = !(sy < ey);
      err_acc = span_x + neg_span_y;
      ink = w.color;
      drawing = 1'b1;
      return 1'b0;
    end
    if (!drawing) return 1'b0;
    on_scr = walk_x >= 0 && walk_x < int'(screen_cfg.screen_width) &&
             walk_y >= 0 && walk_y < int'(screen_cfg.screen_height);
    lin = walk_y * int'(screen_cfg.row_pitch) + walk_x * int'(screen_cfg.pixel_bytes);
    px.px_x = walk_x[CB-1:0];
    px.px_y = walk_y[CB-1:0];
    px.on_screen = on_scr;
    px.offset = on_scr ? lin[OFFSET_BITS-1:0] : '0;
    px.color = ink;
    // error term update, x then y
    fin = 1'b0;
    e2 = 2 * err_acc;
    if (e2 >= neg_span_y) begin
      if (walk_x == goal_x) begin
        fin = 1'b1;
      end else begin
        err_acc += neg_span_y;
        walk_x += x_back ? -1 : 1;
      end
    end
    if (!fin && e2 <= span_x) begin
      if (walk_y == goal_y) begin
        fin = 1'b1;
      end else begin
        err_acc += span_x;
        walk_y += y_back ? -1 : 1;
      end
    end
    px.tail = fin;
    if (fin) drawing = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [IN_W-1:0] pack_stroke(input stroke_t w);
    logic [IN_W-1:0] d;
    d = '0;
    d[CB-1:0] = w.sx;
    d[2*CB-1:CB] = w.sy;
    d[3*CB-1:2*CB] = w.ex;
    d[4*CB-1:3*CB] = w.ey;
    d[4*CB+COLOR_BITS-1:4*CB] = w.color;
    return d;
  endfunction

  function automatic int draw_wait(input int pace);
    case (pace)
      0: return 0;
      1: return $urandom_range(0, 17);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
    endcase
  endfunction

  function automatic void diff_field(input string fld, input logic [31:0] want,
                                     input logic [31:0] seen);
    if (want !== seen) begin
      $display("%0t pixel %s mismatch: expected %h actual %h", $time, fld, want, seen);
      errors++;
    end
  endfunction

  function automatic int clamp_coord(input int v);
    if (v < -2048) return -2048;
    if (v > 2047) return 2047;
    return v;
  endfunction

  // mostly around the visible area, sometimes anywhere
  function automatic int pick_coord(input int extent);
    if ($urandom_range(0, 3) == 0) return int'($urandom_range(0, 4095)) - 2048;
    return clamp_coord(int'($urandom_range(0, extent + 40)) - 20);
  endfunction

  function automatic int pick_delta();
    if ($urandom_range(0, 24) == 0) return int'($urandom_range(0, 400)) - 200;
    return int'($urandom_range(0, 24)) - 12;
  endfunction

  function automatic void push_load(input int sx, input int sy, input int ex, input int ey,
                                    input logic [31:0] color);
    stroke_t w;
    w.cmd = CMD_LOAD;
    w.sx = sx[CB-1:0];
    w.sy = sy[CB-1:0];
    w.ex = ex[CB-1:0];
    w.ey = ey[CB-1:0];
    w.color = color;
    stroke_q.push_back(w);
  endfunction

  // step words carry random payload that the block must ignore
  function automatic void push_step();
    stroke_t w;
    w.cmd = CMD_STEP;
    w.sx = CB'($urandom);
    w.sy = CB'($urandom);
    w.ex = CB'($urandom);
    w.ey = CB'($urandom);
    w.color = $urandom;
    stroke_q.push_back(w);
  endfunction

  // runs of load plus steps, some cut short, some with stray steps
  task automatic fill_random(input int budget);
    int made;
    int kind;
    int sx;
    int sy;
    int ex;
    int ey;
    int len;
    int n;
    made = 0;
    while (made < budget) begin
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        push_step();
        made++;
      end else begin
        sx = pick_coord(int'(screen_cfg.screen_width));
        sy = pick_coord(int'(screen_cfg.screen_height));
        ex = clamp_coord(sx + pick_delta());
        ey = clamp_coord(sy + pick_delta());
        len = ((ex > sx) ? ex - sx : sx - ex);
        if (((ey > sy) ? ey - sy : sy - ey) > len) len = (ey > sy) ? ey - sy : sy - ey;
        len++;
        if (kind <= 2) n = $urandom_range(0, len - 1);
        else n = len + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
        push_load(sx, sy, ex, ey, $urandom);
        repeat (n) push_step();
        made += n + 1;
      end
    end
  endtask

  // one register write per call; caller is at a rising edge
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    case (idx)
      REG_SCREEN_WIDTH:  screen_cfg.screen_width = v[WIDTH_BITS-1:0];
      REG_SCREEN_HEIGHT: screen_cfg.screen_height = v[HEIGHT_BITS-1:0];
      REG_ROW_PITCH:     screen_cfg.row_pitch = v[PITCH_BITS-1:0];
      REG_PIXEL_BYTES:   screen_cfg.pixel_bytes = v[PBYTES_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic program_screen(input int w, input int h, input int p, input int b);
    write_reg(REG_SCREEN_WIDTH, w[CFG_DATA_BITS-1:0]);
    write_reg(REG_SCREEN_HEIGHT, h[CFG_DATA_BITS-1:0]);
    write_reg(REG_ROW_PITCH, p[CFG_DATA_BITS-1:0]);
    write_reg(REG_PIXEL_BYTES, b[CFG_DATA_BITS-1:0]);
    cfg_wr_en <= 1'b0;
  endtask

  // wait until every word is taken and every pixel has come out
  task automatic drain();
    while (stroke_q.size() != 0 || s_axis_tvalid || pixel_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // input side driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (trace_line(on_bus, next_px)) pixel_q.push_back(next_px);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_wait > 0) begin
          send_wait--;
          s_axis_tvalid <= 1'b0;
        end else if (stroke_q.size() != 0) begin
          on_bus = stroke_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= on_bus.cmd;
          s_axis_tdata <= pack_stroke(on_bus);
          send_wait = draw_wait(send_pace);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // output side monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_px.px_x = m_axis_tdata[CB-1:0];
        got_px.px_y = m_axis_tdata[2*CB-1:CB];
        got_px.offset = m_axis_tdata[2*CB+OFFSET_BITS-1:2*CB];
        got_px.color = m_axis_tdata[2*CB+OFFSET_BITS+COLOR_BITS-1:2*CB+OFFSET_BITS];
        got_px.on_screen = m_axis_tuser;
        got_px.tail = m_axis_tlast;
        if (pixel_q.size() == 0) begin
          $display("%0t unexpected pixel word: expected none actual %h", $time, got_px);
          errors++;
        end else begin
          want_px = pixel_q.pop_front();
          diff_field("x", 32'(want_px.px_x), 32'(got_px.px_x));
          diff_field("y", 32'(want_px.px_y), 32'(got_px.px_y));
          diff_field("on_screen", 32'(want_px.on_screen), 32'(got_px.on_screen));
          diff_field("offset", 32'(want_px.offset), 32'(got_px.offset));
          diff_field("colour", want_px.color, got_px.color);
          diff_field("last", 32'(want_px.tail), 32'(got_px.tail));
        end
        recv_wait = draw_wait(recv_pace);
      end
      // one long back-pressure stretch so the block fills up
      if (hold_req && !hold_done) begin
        recv_wait = 400;
        hold_done = 1'b1;
      end
      if (recv_wait > 0) begin
        recv_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // run-time limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // phases: screen settings, pacing and stimulus
  initial begin
    screen_cfg.screen_width = SCREEN_WIDTH_RST;
    screen_cfg.screen_height = SCREEN_HEIGHT_RST;
    screen_cfg.row_pitch = ROW_PITCH_RST;
    screen_cfg.pixel_bytes = PIXEL_BYTES_RST;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: ;
        1: program_screen(4095, 4095, 32767, 7);
        2: program_screen(1, 1, 1, 1);
        3: program_screen(0, 0, 0, 0);
        4: program_screen(2048, 2048, 16384, 4);
        default: begin
          if ($urandom_range(0, 2) == 0)
            program_screen($urandom_range(0, 4095), $urandom_range(0, 4095),
                           $urandom_range(0, 32767), $urandom_range(0, 7));
          else
            program_screen($urandom_range(1, 2048), $urandom_range(1, 2048),
                           $urandom_range(1, 16384), $urandom_range(1, 4));
        end
      endcase
      case (p)
        0: begin send_pace = 1; recv_pace = 1; end
        1: begin send_pace = 0; recv_pace = 0; end
        2: begin send_pace = 0; recv_pace = 2; end
        3: begin send_pace = 1; recv_pace = 0; end
        default: begin
          send_pace = $urandom_range(0, 2);
          recv_pace = $urandom_range(0, 2);
        end
      endcase
      if (p == 0) begin
        // step with no line, single-point line, screen edge crossing
        push_step();
        push_load(5, 5, 5, 5, 32'h0000_0000);
        push_step();
        push_step();
        push_load(958, 538, 961, 541, 32'hFFFF_FFFF);
        repeat (5) push_step();
        // corners of the coordinate range
        push_load(-2048, 2047, -2046, 2045, 32'h5A5A_A5A5);
        repeat (3) push_step();
        push_load(2047, -2048, 2045, -2047, 32'hA5A5_5A5A);
        repeat (3) push_step();
        // new line dropped in while the old one is running
        push_load(1, 0, -1, 3, $urandom);
        push_step();
        push_load(0, 0, 0, -2, $urandom);
        repeat (3) push_step();
      end
      if (p == 2) begin
        hold_req = 1'b1;
        push_load(0, 0, 59, 17, $urandom);
        repeat (60) push_step();
      end
      fill_random(PHASE_LEN);
      drain();
    end
    repeat (8) @(posedge clk);
    if (errors == 0 && pixel_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
